// ===== rtl/mutex_lock_unit_with_wait_queue_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the mutex lock unit
// Thin wrappers around clocked concurrent assertions with reset disable.
// ----------------------------------------------------------------------------
`ifndef MUTEX_LOCK_UNIT_WITH_WAIT_QUEUE_UNIT_MACROS_SVH
`define MUTEX_LOCK_UNIT_WITH_WAIT_QUEUE_UNIT_MACROS_SVH

// same-cycle implication
`define MLU_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mutex lock unit: assertion failed");

// next-cycle implication
`define MLU_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mutex lock unit: assertion failed");

`endif

// ===== rtl/mlu_pkg.sv =====
// ----------------------------------------------------------------------------
// mlu_pkg
// Shared widths, defaults and codes of the mutex lock unit.
// ----------------------------------------------------------------------------
package mlu_pkg;

   // fixed field widths
   localparam int CMD_W    = 2;
   localparam int TID_W    = 8;
   localparam int STATUS_W = 3;
   localparam int TYPE_W   = 2;

   // config port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // parameter defaults
   localparam int QUEUE_DEPTH_DEF    = 16;
   localparam int MAX_RECURSION_DEF  = 255;
   localparam int THREAD_ID_BITS_DEF = 8;

   typedef enum logic [CMD_W-1:0] {
      CMD_TRYLOCK = 2'd0,
      CMD_LOCK    = 2'd1,
      CMD_UNLOCK  = 2'd2,
      CMD_NOP     = 2'd3
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 3'd0,
      ST_BUSY      = 3'd1,
      ST_DEADLOCK  = 3'd2,
      ST_AGAIN     = 3'd3,
      ST_OVERFLOW  = 3'd4,
      ST_NOT_OWNER = 3'd5
   } status_type;

   typedef enum logic [TYPE_W-1:0] {
      MT_NORMAL     = 2'd0,
      MT_ERRORCHECK = 2'd1,
      MT_RECURSIVE  = 2'd2,
      MT_UNUSED     = 2'd3
   } mtype_type;

   // register index of mutex_type
   localparam logic REG_MUTEX_TYPE = 1'b0;

   typedef enum logic {
      S_IDLE = 1'b0,
      S_EXEC = 1'b1
   } state_type;

endpackage

// ===== rtl/mlu_ram.sv =====
// ----------------------------------------------------------------------------
// mlu_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mlu_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 16,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/mutex_lock_unit_with_wait_queue_unit.sv =====
// ----------------------------------------------------------------------------
// mutex_lock_unit_with_wait_queue_unit
// One hardware mutex with owner, recursion count and a FIFO ring of waiters.
//
//   channel | dir | handshake            | word
//   req     | in  | req_valid/req_stall  | command, thread_id
//   rsp     | out | rsp_valid/rsp_stall  | status, blocked, woken, owner
//   csr     | in  | psel/penable/pready  | mutex_type at byte address 0
//
// Each word goes from idle to execute (the waiter RAM has registered read data):
// the accept edge launches the ring read of the head slot; commit, once the
// result register is free, applies the update and loads the result register.
// Reset is synchronous; the waiter ring is not cleared (a slot is only read
// after it has been written), so no clearing pass is needed.
// A stalled result holds; one more word is taken and waits in execute.
// ----------------------------------------------------------------------------
`include "mutex_lock_unit_with_wait_queue_unit_macros.svh"

module mutex_lock_unit_with_wait_queue_unit #(
   parameter int QUEUE_DEPTH    = mlu_pkg::QUEUE_DEPTH_DEF,
   parameter int MAX_RECURSION  = mlu_pkg::MAX_RECURSION_DEF,
   parameter int THREAD_ID_BITS = mlu_pkg::THREAD_ID_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   // request
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [mlu_pkg::CMD_W-1:0]     req_command,
   input  logic [mlu_pkg::TID_W-1:0]     req_thread_id,
   // response
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [mlu_pkg::STATUS_W-1:0]  rsp_status,
   output logic                          rsp_caller_blocked,
   output logic                          rsp_woken_valid,
   output logic [mlu_pkg::TID_W-1:0]     rsp_woken_thread,
   output logic                          rsp_owner_valid,
   output logic [mlu_pkg::TID_W-1:0]     rsp_owner_thread,
   // config
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [mlu_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [mlu_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [mlu_pkg::CSR_DATA_W-1:0] prdata,
   output logic                          pready
);
   import mlu_pkg::*;

   // stored thread id width: ids are masked to THREAD_ID_BITS
   localparam int ID_W   = (THREAD_ID_BITS < TID_W) ? THREAD_ID_BITS : TID_W;
   localparam int IDX_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
   localparam int RC_W   = $clog2(MAX_RECURSION + 1);

   // ---------------- config register ----------------
   logic [TYPE_W-1:0] mtype_ff;
   logic              csr_wr;

   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         mtype_ff <= MT_NORMAL;
      end else if (csr_wr && paddr[2] == REG_MUTEX_TYPE) begin
         mtype_ff <= pwdata[TYPE_W-1:0];
      end
   end

   assign prdata = (paddr[2] == REG_MUTEX_TYPE) ? CSR_DATA_W'(mtype_ff) : '0;

   // ---------------- mutex state ----------------
   state_type          state_ff, state_in;
   logic               held_ff, held_in;
   logic [ID_W-1:0]    owner_ff, owner_in;
   logic [RC_W-1:0]    rc_ff, rc_in;
   logic [IDX_W-1:0]   head_ff, head_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;

   // latched request word
   logic [CMD_W-1:0]   cmd_ff;
   logic [ID_W-1:0]    tid_ff;

   // result register
   logic               rsp_valid_ff, rsp_valid_in;
   status_type         status_ff, status_in;
   logic               blocked_ff, blocked_in;
   logic               wvalid_ff, wvalid_in;
   logic [ID_W-1:0]    wthread_ff, wthread_in;
   logic               oval_ff;
   logic [ID_W-1:0]    othread_ff;

   // ring access
   logic               ring_we;
   logic [IDX_W-1:0]   ring_tail;
   logic [CNT_W:0]     tail_sum;
   logic [IDX_W-1:0]   head_nxt;
   logic [ID_W-1:0]    ring_rd;

   logic               accept;
   logic               commit;
   logic               is_owner;

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign commit    = (state_ff == S_EXEC) && (!rsp_valid_ff || !rsp_stall);
   assign is_owner  = held_ff && (owner_ff == tid_ff);

   // tail slot = (head + count) mod depth; sum stays below twice the depth
   assign tail_sum  = (CNT_W+1)'(head_ff) + (CNT_W+1)'(cnt_ff);
   assign ring_tail = (tail_sum >= (CNT_W+1)'(QUEUE_DEPTH))
                      ? IDX_W'(tail_sum - (CNT_W+1)'(QUEUE_DEPTH))
                      : IDX_W'(tail_sum);
   assign head_nxt  = (head_ff == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : head_ff + 1'b1;

   // head slot is read every cycle; head only moves at commit, and a write
   // lands at its commit edge, before the edge that launches the next word's read
   mlu_ram #(
      .WIDTH (ID_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ring_we),
      .wr_addr (ring_tail),
      .wr_data (tid_ff),
      .rd_addr (head_ff),
      .rd_data (ring_rd)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         held_ff      <= 1'b0;
         owner_ff     <= '0;
         rc_ff        <= '0;
         head_ff      <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         held_ff      <= held_in;
         owner_ff     <= owner_in;
         rc_ff        <= rc_in;
         head_ff      <= head_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff <= req_command;
         tid_ff <= req_thread_id[ID_W-1:0];
      end
      if (commit) begin
         status_ff  <= status_in;
         blocked_ff <= blocked_in;
         wvalid_ff  <= wvalid_in;
         wthread_ff <= wthread_in;
         oval_ff    <= held_in;
         othread_ff <= owner_in;
      end
   end

   // next state and datapath
   always_comb begin
      state_in     = state_ff;
      held_in      = held_ff;
      owner_in     = owner_ff;
      rc_in        = rc_ff;
      head_in      = head_ff;
      cnt_in       = cnt_ff;
      status_in    = ST_OK;
      blocked_in   = 1'b0;
      wvalid_in    = 1'b0;
      wthread_in   = '0;
      ring_we      = 1'b0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (commit) begin
               state_in     = S_IDLE;
               rsp_valid_in = 1'b1;
               case (cmd_ff)
                  CMD_TRYLOCK, CMD_LOCK: begin
                     if (is_owner && mtype_ff == MT_ERRORCHECK) begin
                        status_in = ST_DEADLOCK;
                     end else if (is_owner && mtype_ff == MT_RECURSIVE) begin
                        if (rc_ff == RC_W'(MAX_RECURSION)) begin
                           status_in = ST_AGAIN;
                        end else begin
                           rc_in = rc_ff + 1'b1;
                        end
                     end else if (!held_ff) begin
                        held_in  = 1'b1;
                        owner_in = tid_ff;
                        rc_in    = '0;
                     end else if (cmd_ff == CMD_LOCK) begin
                        // busy: queue the caller at the tail
                        if (cnt_ff == CNT_W'(QUEUE_DEPTH)) begin
                           status_in = ST_OVERFLOW;
                        end else begin
                           ring_we    = 1'b1;
                           cnt_in     = cnt_ff + 1'b1;
                           blocked_in = 1'b1;
                        end
                     end else begin
                        status_in = ST_BUSY;
                     end
                  end
                  CMD_UNLOCK: begin
                     if (!is_owner) begin
                        status_in = ST_NOT_OWNER;
                     end else if (mtype_ff == MT_RECURSIVE && rc_ff != '0) begin
                        rc_in = rc_ff - 1'b1;
                     end else begin
                        rc_in = '0;
                        if (cnt_ff == '0) begin
                           held_in  = 1'b0;
                           owner_in = '0;
                        end else begin
                           // hand off to the oldest waiter
                           owner_in   = ring_rd;
                           head_in    = head_nxt;
                           cnt_in     = cnt_ff - 1'b1;
                           wvalid_in  = 1'b1;
                           wthread_in = ring_rd;
                        end
                     end
                  end
                  default: begin
                     // unused command: no change
                  end
               endcase
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = status_ff;
   assign rsp_caller_blocked = blocked_ff;
   assign rsp_woken_valid    = wvalid_ff;
   assign rsp_woken_thread   = TID_W'(wthread_ff);
   assign rsp_owner_valid    = oval_ff;
   assign rsp_owner_thread   = TID_W'(othread_ff);

   // ---------------- assertions ----------------
   // ring never overfills
   `MLU_ASSERT_IMP(a_cnt_range, clock, reset, 1'b1, cnt_ff <= CNT_W'(QUEUE_DEPTH))
   // waiters only exist behind a holder
   `MLU_ASSERT_IMP(a_wait_held, clock, reset, cnt_ff != '0, held_ff)
   // a free mutex has no owner and no recursion
   `MLU_ASSERT_IMP(a_free_clean, clock, reset, !held_ff, owner_ff == '0 && rc_ff == '0)
   // an accepted word goes to execute
   `MLU_ASSERT_NXT(a_acc_exec, clock, reset, accept, state_ff == S_EXEC)
   // a woken waiter is reported as the new owner
   `MLU_ASSERT_IMP(a_woken_owner, clock, reset, rsp_valid && rsp_woken_valid,
                   rsp_owner_valid && rsp_owner_thread == rsp_woken_thread)

endmodule
